// ----- rtl/core/swbr_pkg.sv -----
// shared types and constants for the sinusoidal warp / bilinear remap block
// no dependencies; imported by every module under rtl/core
package swbr_pkg;

    // default sizes, handed to the top level parameters
    localparam int SWBR_MAX_ROWS         = 512;
    localparam int SWBR_MAX_COLS         = 512;
    localparam int SWBR_SINE_TABLE_DEPTH = 1024;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_FRAME_ROWS    = 3'd0;
    localparam logic [2:0] REG_FRAME_COLS    = 3'd1;
    localparam logic [2:0] REG_ROW_AMPLITUDE = 3'd2;
    localparam logic [2:0] REG_ROW_FREQUENCY = 3'd3;
    localparam logic [2:0] REG_ROW_PHASE     = 3'd4;
    localparam logic [2:0] REG_COL_AMPLITUDE = 3'd5;
    localparam logic [2:0] REG_COL_FREQUENCY = 3'd6;
    localparam logic [2:0] REG_COL_PHASE     = 3'd7;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // pi/2 in Q30 for the sine table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // x / 45 by reciprocal, exact for x below 74898
    localparam int QUOT_MUL   = 46604;
    localparam int QUOT_SHIFT = 21;
    localparam int TURN_DIV   = 45;
    // 8192 = 182 * 45 + 2
    localparam int TURN_STEP  = 182;

    typedef struct packed {
        logic [9:0]        frame_rows;
        logic [9:0]        frame_cols;
        logic signed [7:0] row_amplitude;
        logic [6:0]        row_frequency;
        logic [15:0]       row_phase;
        logic signed [7:0] col_amplitude;
        logic [6:0]        col_frequency;
        logic [15:0]       col_phase;
    } cfg_t;

endpackage

// ----- rtl/core/swbr_cfg_regs.sv -----
// configuration register file behind the APB-style port
// depends on swbr_pkg (cfg_t, register indexes)
module swbr_cfg_regs
    import swbr_pkg::*;
#(
    parameter int MAX_ROWS = SWBR_MAX_ROWS,
    parameter int MAX_COLS = SWBR_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    localparam logic [9:0] ROWS_RESET = 10'(MAX_ROWS < 512 ? MAX_ROWS : 512);
    localparam logic [9:0] COLS_RESET = 10'(MAX_COLS < 512 ? MAX_COLS : 512);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_ROWS:
                begin
                    // sizes beyond the store clamp to the store
                    if (32'(pwdata[9:0]) > MAX_ROWS)
                        cfg_next.frame_rows = 10'(MAX_ROWS);
                    else
                        cfg_next.frame_rows = pwdata[9:0];
                end
                REG_FRAME_COLS:
                begin
                    if (32'(pwdata[9:0]) > MAX_COLS)
                        cfg_next.frame_cols = 10'(MAX_COLS);
                    else
                        cfg_next.frame_cols = pwdata[9:0];
                end
                REG_ROW_AMPLITUDE: cfg_next.row_amplitude = pwdata[7:0];
                REG_ROW_FREQUENCY: cfg_next.row_frequency = pwdata[6:0];
                REG_ROW_PHASE:     cfg_next.row_phase     = pwdata[15:0];
                REG_COL_AMPLITUDE: cfg_next.col_amplitude = pwdata[7:0];
                REG_COL_FREQUENCY: cfg_next.col_frequency = pwdata[6:0];
                REG_COL_PHASE:     cfg_next.col_phase     = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_ROWS:    prdata = 32'(cfg_reg.frame_rows);
            REG_FRAME_COLS:    prdata = 32'(cfg_reg.frame_cols);
            REG_ROW_AMPLITUDE: prdata = 32'(unsigned'(cfg_reg.row_amplitude));
            REG_ROW_FREQUENCY: prdata = 32'(cfg_reg.row_frequency);
            REG_ROW_PHASE:     prdata = 32'(cfg_reg.row_phase);
            REG_COL_AMPLITUDE: prdata = 32'(unsigned'(cfg_reg.col_amplitude));
            REG_COL_FREQUENCY: prdata = 32'(cfg_reg.col_frequency);
            REG_COL_PHASE:     prdata = 32'(cfg_reg.col_phase);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= '0;
            cfg_reg.frame_rows    <= ROWS_RESET;
            cfg_reg.frame_cols    <= COLS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/swbr_sine_rom.sv -----
// Q1.14 sine table over one full turn, registered read
// depends on swbr_pkg (HALF_PI_Q30); entries built at elaboration
module swbr_sine_rom
    import swbr_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SWBR_SINE_TABLE_DEPTH
)
(
    input  logic                                clk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output logic signed [15:0]                  rd_data
);

    // quarter-wave fold, then Taylor series to the a^13 term
    function automatic logic signed [15:0] sine_q14(input int unsigned k);
        longint unsigned d;
        longint unsigned q;
        longint unsigned u;
        longint unsigned a;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        logic            neg;
        d   = longint'(SINE_TABLE_DEPTH);
        q   = 4 * longint'(k);
        neg = 1'b0;
        if (q <= d)
            u = q;
        else if (q <= 2 * d)
            u = 2 * d - q;
        else if (q <= 3 * d)
        begin
            u   = q - 2 * d;
            neg = 1'b1;
        end
        else
        begin
            u   = 4 * d - q;
            neg = 1'b1;
        end
        a = (HALF_PI_Q30 * u + longint'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        t = a;
        s = a;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 6;   s = s - t;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 20;  s = s + t;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 42;  s = s - t;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 72;  s = s + t;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 110; s = s - t;
        t = (t * a) >> 30; t = (t * a) >> 30; t = t / 156; s = s + t;
        r = (s + 64'd32768) >> 16;
        if (r > 64'd16384)
            r = 64'd16384;
        return neg ? -16'(r) : 16'(r);
    endfunction

    logic signed [15:0] sine_tbl [SINE_TABLE_DEPTH];
    logic signed [15:0] data_reg;

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++)
    begin : g_entry
        localparam logic signed [15:0] ENTRY = sine_q14(i);
        assign sine_tbl[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= sine_tbl[addr];
    end

    assign rd_data = data_reg;

endmodule

// ----- rtl/core/swbr_frame_mem.sv -----
// frame store: one write port, one read port with registered data
// depends on swbr_pkg for default sizes
module swbr_frame_mem
    import swbr_pkg::*;
#(
    parameter int MAX_ROWS = SWBR_MAX_ROWS,
    parameter int MAX_COLS = SWBR_MAX_COLS
)
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] wr_addr,
    input  logic [7:0]                           wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] rd_addr,
    output logic [7:0]                           rd_data
);

    logic [7:0] mem [MAX_ROWS*MAX_COLS];
    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

    assign rd_data = data_reg;

endmodule

// ----- rtl/core/sinusoidal_warp_bilinear_remap.sv -----
// sinusoidal warp with bilinear resampling over a stored grayscale frame
// depends on swbr_pkg, swbr_cfg_regs, swbr_sine_rom, swbr_frame_mem
//
// Request channel (req_valid / req_stall) carries req_type, pix_row, pix_col,
// pix_value; a transfer happens on a clock edge with req_valid high and
// req_stall low. A write request stores pix_value at (pix_row, pix_col) in the
// same edge and gives no result; writes outside the configured frame are
// dropped. A write leaves the step sequencer in idle.
// A read request gives one result on the response channel (rsp_valid /
// rsp_stall): warped_value and outside_frame. The result of a read becomes
// valid at the same edge at which the block returns to idle, so the next
// request can be taken while it is shown; a read holds the block until then.
// The step sequencer runs quotient, turn phase and sine index, then two
// lookups through the single sine table port and the displacement products,
// source coordinates and weights, then four neighbour reads through the
// single frame memory port and the final blend.
// The response register holds its result while rsp_stall is high; a new
// request is still taken, and a read finishes into the register once it
// frees up. Configuration is to be written over the APB-style port while
// the block is idle; the block itself does not enforce this. Reset clears
// the sequencer and the response valid and loads the register defaults;
// the frame store is not cleared and needs no clearing pass.
module sinusoidal_warp_bilinear_remap
    import swbr_pkg::*;
#(
    parameter int MAX_ROWS         = SWBR_MAX_ROWS,
    parameter int MAX_COLS         = SWBR_MAX_COLS,
    parameter int SINE_TABLE_DEPTH = SWBR_SINE_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  req_type,
    input  logic [8:0]            pix_row,
    input  logic [8:0]            pix_col,
    input  logic [7:0]            pix_value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [7:0]            warped_value,
    output logic                  outside_frame
);

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int KW = $clog2(SINE_TABLE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QUOT   = 4'd1;
    localparam logic [3:0] S_TURN   = 4'd2;
    localparam logic [3:0] S_INDEX  = 4'd3;
    localparam logic [3:0] S_SIN_R  = 4'd4;
    localparam logic [3:0] S_SIN_C  = 4'd5;
    localparam logic [3:0] S_DISP   = 4'd6;
    localparam logic [3:0] S_COORD  = 4'd7;
    localparam logic [3:0] S_WEIGHT = 4'd8;
    localparam logic [3:0] S_FETCH  = 4'd9;
    localparam logic [3:0] S_BLEND  = 4'd10;

    // phase in 1/65536 turn: turn = x*8192/45 with x = q*45 + rem
    function automatic logic [15:0] turn_phase(input logic [15:0] x,
                                               input logic [10:0] q,
                                               input logic [15:0] phase);
        logic [15:0] rem16;
        logic [5:0]  rem;
        logic [12:0] frac;
        rem16 = x - 16'(32'(q) * 32'(TURN_DIV));
        rem   = rem16[5:0];
        frac  = 13'(32'(rem) * 32'(TURN_STEP)) + 13'(rem >= 6'd12) + 13'(rem >= 6'd34);
        return {q[2:0], frac} - phase;
    endfunction

    // phase to table index, rounded, wrapped into the table
    function automatic logic [KW-1:0] table_index(input logic [15:0] p);
        logic [31:0] kk;
        kk = (32'(p) * 32'(SINE_TABLE_DEPTH) + 32'd32768) >> 16;
        if (kk == 32'(SINE_TABLE_DEPTH))
            return '0;
        return kk[KW-1:0];
    endfunction

    // row or column of a neighbour inside [0, size)
    function automatic logic coord_inside(input logic [11:0] v, input logic [9:0] size);
        return !v[11] && (v[10:0] < {1'b0, size});
    endfunction

    function automatic logic [15:0] source_coord(input logic [8:0] pos,
                                                 input logic signed [23:0] dprod);
        logic [23:0] dsum;
        dsum = dprod + 24'sd256;
        return {2'b00, pos, 5'b00000} + {dsum[23], dsum[23:9]};
    endfunction

    cfg_t cfg;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         nbr_reg, nbr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [7:0]         warped_value_reg, warped_value_next;
    logic               outside_frame_reg, outside_frame_next;

    logic [8:0]         row_reg, row_next;
    logic [8:0]         col_reg, col_next;
    logic [15:0]        x_row_reg, x_row_next;
    logic [15:0]        x_col_reg, x_col_next;
    logic [10:0]        q_row_reg, q_row_next;
    logic [10:0]        q_col_reg, q_col_next;
    logic [15:0]        p_row_reg, p_row_next;
    logic [15:0]        p_col_reg, p_col_next;
    logic [KW-1:0]      k_row_reg, k_row_next;
    logic [KW-1:0]      k_col_reg, k_col_next;
    logic signed [23:0] dprod_row_reg, dprod_row_next;
    logic signed [23:0] dprod_col_reg, dprod_col_next;
    logic [11:0]        r0_reg, r0_next;
    logic [11:0]        c0_reg, c0_next;
    logic [4:0]         fr_reg, fr_next;
    logic [4:0]         fc_reg, fc_next;
    logic [3:0]         inside_reg, inside_next;
    logic [10:0]        w_reg [4];
    logic [10:0]        w_next [4];
    logic [18:0]        acc_reg, acc_next;

    logic               req_accept;
    logic               rsp_room;
    logic [KW-1:0]      rom_addr;
    logic signed [15:0] sine_data;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [7:0]         mem_rd_data;
    logic [11:0]        fetch_r;
    logic [11:0]        fetch_c;
    logic [1:0]         term_idx;
    logic [7:0]         term_pix;
    logic [18:0]        term_prod;
    logic [15:0]        sr;
    logic [15:0]        sc;
    logic [5:0]         fr_lo;
    logic [5:0]         fc_lo;
    logic [11:0]        nb_r;
    logic [11:0]        nb_c;

    swbr_cfg_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swbr_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (sine_data)
    );

    swbr_frame_mem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_frame (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (pix_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign req_stall     = (state_reg != S_IDLE);
    assign req_accept    = req_valid && !req_stall;
    assign rsp_valid     = rsp_valid_reg;
    assign warped_value  = warped_value_reg;
    assign outside_frame = outside_frame_reg;
    assign rsp_room      = !rsp_valid_reg || !rsp_stall;

    assign rom_addr = (state_reg == S_SIN_R) ? k_row_reg : k_col_reg;

    // writes come straight from the request ports; reads only run outside idle
    assign mem_wr_addr = AW'(32'(pix_row) * 32'(MAX_COLS) + 32'(pix_col));
    assign fetch_r     = r0_reg + 12'(nbr_reg[1]);
    assign fetch_c     = c0_reg + 12'(nbr_reg[0]);
    assign mem_rd_addr = AW'(32'(fetch_r[RW-1:0]) * 32'(MAX_COLS) + 32'(fetch_c[CW-1:0]));

    // neighbour whose pixel arrives this cycle
    assign term_idx  = (state_reg == S_BLEND) ? 2'd3 : (nbr_reg - 2'd1);
    assign term_pix  = inside_reg[term_idx] ? mem_rd_data : 8'd0;
    assign term_prod = 19'(w_reg[term_idx]) * 19'(term_pix);

    assign sr    = source_coord(row_reg, dprod_row_reg);
    assign sc    = source_coord(col_reg, dprod_col_reg);
    assign fr_lo = 6'd32 - {1'b0, fr_reg};
    assign fc_lo = 6'd32 - {1'b0, fc_reg};
    assign nb_r  = r0_reg + 12'd1;
    assign nb_c  = c0_reg + 12'd1;

    always_comb
    begin
        state_next         = state_reg;
        nbr_next           = nbr_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        warped_value_next  = warped_value_reg;
        outside_frame_next = outside_frame_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        x_row_next         = x_row_reg;
        x_col_next         = x_col_reg;
        q_row_next         = q_row_reg;
        q_col_next         = q_col_reg;
        p_row_next         = p_row_reg;
        p_col_next         = p_col_reg;
        k_row_next         = k_row_reg;
        k_col_next         = k_col_reg;
        dprod_row_next     = dprod_row_reg;
        dprod_col_next     = dprod_col_reg;
        r0_next            = r0_reg;
        c0_next            = c0_reg;
        fr_next            = fr_reg;
        fc_next            = fc_reg;
        inside_next        = inside_reg;
        w_next             = w_reg;
        acc_next           = acc_reg;
        mem_wr_en          = 1'b0;
        mem_rd_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_type == REQ_READ)
                    begin
                        row_next   = pix_row;
                        col_next   = pix_col;
                        x_row_next = 16'(pix_col) * 16'(cfg.row_frequency);
                        x_col_next = 16'(pix_row) * 16'(cfg.col_frequency);
                        state_next = S_QUOT;
                    end
                    else if (({1'b0, pix_row} < cfg.frame_rows) &&
                             ({1'b0, pix_col} < cfg.frame_cols))
                    begin
                        mem_wr_en = 1'b1;
                    end
                end
            end
            S_QUOT:
            begin
                q_row_next = 11'((32'(x_row_reg) * 32'(QUOT_MUL)) >> QUOT_SHIFT);
                q_col_next = 11'((32'(x_col_reg) * 32'(QUOT_MUL)) >> QUOT_SHIFT);
                state_next = S_TURN;
            end
            S_TURN:
            begin
                p_row_next = turn_phase(x_row_reg, q_row_reg, cfg.row_phase);
                p_col_next = turn_phase(x_col_reg, q_col_reg, cfg.col_phase);
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                k_row_next = table_index(p_row_reg);
                k_col_next = table_index(p_col_reg);
                state_next = S_SIN_R;
            end
            S_SIN_R:
            begin
                state_next = S_SIN_C;
            end
            S_SIN_C:
            begin
                dprod_row_next = 24'(cfg.row_amplitude) * 24'(sine_data);
                state_next     = S_DISP;
            end
            S_DISP:
            begin
                dprod_col_next = 24'(cfg.col_amplitude) * 24'(sine_data);
                state_next     = S_COORD;
            end
            S_COORD:
            begin
                // floor of the 5-bit fixed point coordinate and its fraction
                r0_next    = {sr[15], sr[15:5]};
                c0_next    = {sc[15], sc[15:5]};
                fr_next    = sr[4:0];
                fc_next    = sc[4:0];
                state_next = S_WEIGHT;
            end
            S_WEIGHT:
            begin
                inside_next[0] = coord_inside(r0_reg, cfg.frame_rows) &&
                                 coord_inside(c0_reg, cfg.frame_cols);
                inside_next[1] = coord_inside(r0_reg, cfg.frame_rows) &&
                                 coord_inside(nb_c, cfg.frame_cols);
                inside_next[2] = coord_inside(nb_r, cfg.frame_rows) &&
                                 coord_inside(c0_reg, cfg.frame_cols);
                inside_next[3] = coord_inside(nb_r, cfg.frame_rows) &&
                                 coord_inside(nb_c, cfg.frame_cols);
                w_next[0]  = 11'(fr_lo) * 11'(fc_lo);
                w_next[1]  = 11'(fr_lo) * 11'(fc_reg);
                w_next[2]  = 11'(fr_reg) * 11'(fc_lo);
                w_next[3]  = 11'(fr_reg) * 11'(fc_reg);
                acc_next   = 19'd512;
                nbr_next   = 2'd0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                // issue one neighbour read, fold in the one read last cycle
                mem_rd_en = 1'b1;
                if (nbr_reg != 2'd0)
                    acc_next = acc_reg + term_prod;
                nbr_next = nbr_reg + 2'd1;
                if (nbr_reg == 2'd3)
                    state_next = S_BLEND;
            end
            S_BLEND:
            begin
                if (rsp_room)
                begin
                    acc_next           = acc_reg + term_prod;
                    warped_value_next  = acc_next[17:10];
                    outside_frame_next = !(|inside_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nbr_reg       <= 2'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nbr_reg       <= nbr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        warped_value_reg  <= warped_value_next;
        outside_frame_reg <= outside_frame_next;
        row_reg           <= row_next;
        col_reg           <= col_next;
        x_row_reg         <= x_row_next;
        x_col_reg         <= x_col_next;
        q_row_reg         <= q_row_next;
        q_col_reg         <= q_col_next;
        p_row_reg         <= p_row_next;
        p_col_reg         <= p_col_next;
        k_row_reg         <= k_row_next;
        k_col_reg         <= k_col_next;
        dprod_row_reg     <= dprod_row_next;
        dprod_col_reg     <= dprod_col_next;
        r0_reg            <= r0_next;
        c0_reg            <= c0_next;
        fr_reg            <= fr_next;
        fc_reg            <= fc_next;
        inside_reg        <= inside_next;
        w_reg             <= w_next;
        acc_reg           <= acc_next;
    end

endmodule
